### rtl/sgmd_pkg.sv
// ----------------------------------------------------------------------------
// sgmd_pkg
// Shared constants and tables for the Sobel gradient block.
// ----------------------------------------------------------------------------
package sgmd_pkg;

  localparam int CORDIC_STEPS = 15;
  localparam int ANGLE_W      = 18;
  localparam int CFG_W        = 16;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic signed [15:0] DIR_ZERO   = 16'sd0;
  localparam logic signed [15:0] DIR_PI     = 16'sd32767;
  localparam logic signed [15:0] DIR_UP     = 16'sd16384;
  localparam logic signed [15:0] DIR_DOWN   = -16'sd16384;
  localparam logic signed [ANGLE_W-1:0] ANG_PI = 18'sd32768;

  function automatic logic [13:0] atan_unit(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/sobel_gradient_magnitude_direction.sv
// Result path: an item that yields a result passes the window, square, sum
// and iteration states, the iteration state driving the shared square-root/CORDIC
// unit that retires one bit and one rotation per cycle; other items return to idle.
// Throughput: one item in flight; stall is high until the result is taken.
// Reset: synchronous; clears counters, window and config to 640 x 480 x 3.
// Line store contents are not cleared.
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_direction
// Streaming 3x3 Sobel filter with line stores in RAM, emitting gradient
// magnitude and direction per pixel.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_direction #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int SAMPLE_BITS    = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [sgmd_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [7:0]                chan0_value,
  input  logic [7:0]                chan1_value,
  input  logic [7:0]                chan2_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [12:0]               grad_magnitude,
  output logic signed [15:0]        grad_direction,
  output logic                      frame_last
);
  import sgmd_pkg::*;

  localparam int PW  = SAMPLE_BITS + 2;
  localparam int GW  = PW + 3;
  localparam int RW  = GW;
  localparam int SQW = 2 * RW;
  localparam int XW  = RW + 18;
  localparam int CW  = $clog2(MAX_LINE_WIDTH);
  localparam int WW  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int RWW = 17;
  localparam int NIT = (RW > CORDIC_STEPS) ? RW : CORDIC_STEPS;
  localparam int NW  = $clog2(NIT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WIN  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_ITER = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  state;
  logic [10:0] frame_width;
  logic [15:0] frame_height;
  logic [1:0]  channel_count;

  logic [CW-1:0]  col;
  logic [RWW-1:0] row;
  logic [PW-1:0]  upper_mem [MAX_LINE_WIDTH];
  logic [PW-1:0]  middle_mem [MAX_LINE_WIDTH];
  logic [PW-1:0]  upper_rd, middle_rd, pix;
  logic           cmd;
  logic [PW-1:0]  win [9];

  logic signed [GW-1:0] gx, gy;
  logic [SQW-1:0] sqx, sqy, opnd;
  logic [RW+1:0]  rem;
  logic [RW-1:0]  root;
  logic signed [XW-1:0] cx, cy;
  logic signed [ANGLE_W-1:0] cz;
  logic           spec;
  logic signed [15:0] spec_dir;
  logic           last;
  logic [NW-1:0]  cnt;

  // effective geometry
  logic [WW-1:0]  w_eff;
  logic [RWW-1:0] h_eff;
  logic [CW-1:0]  ncol;
  logic [RWW-1:0] nrow;
  logic [PW-1:0]  pix_next;
  logic [1:0]     cc;

  always_comb begin
    if (frame_width == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > MAX_LINE_WIDTH) begin
      w_eff = WW'(MAX_LINE_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    h_eff = (frame_height == 16'd0) ? RWW'(1) : RWW'(frame_height);
    ncol = col;
    nrow = row;
    if (32'(col) >= 32'(w_eff)) begin
      ncol = '0;
      nrow = row + RWW'(1);
    end
    if (nrow > h_eff + RWW'(1)) begin
      nrow = h_eff + RWW'(1);
      ncol = '0;
    end
    if (nrow == h_eff + RWW'(1)) begin
      ncol = '0;
    end
    cc = (channel_count == 2'd0) ? 2'd1 : channel_count;
    pix_next = PW'(SAMPLE_BITS'(chan0_value));
    if (cc >= 2'd2) begin
      pix_next = pix_next + PW'(SAMPLE_BITS'(chan1_value));
    end
    if (cc >= 2'd3) begin
      pix_next = pix_next + PW'(SAMPLE_BITS'(chan2_value));
    end
  end

  // window step
  logic           drain, stray, corner, fin, emit;
  logic [PW-1:0]  nwin [9];
  logic [PW-1:0]  top;
  logic [PW-1:0]  a [3][3];
  logic [1:0]     sl, sc, sr;
  logic signed [GW-1:0] gx_next, gy_next;
  logic [CW:0]    colp;

  always_comb begin
    drain  = row >= h_eff;
    stray  = !drain && (cmd == CMD_FLUSH);
    corner = !stray && (col == '0) && (row >= RWW'(2));
    fin    = !stray && (row == h_eff + RWW'(1));
    emit   = !stray && !fin && (col != '0) && (row >= RWW'(1));
    top    = (row == RWW'(1)) ? middle_rd : upper_rd;
    for (int r = 0; r < 3; r++) begin
      nwin[r*3]   = win[r*3+1];
      nwin[r*3+1] = win[r*3+2];
    end
    nwin[2] = top;
    nwin[5] = middle_rd;
    nwin[8] = drain ? middle_rd : pix;
    if (corner) begin
      sl = (w_eff == WW'(1)) ? 2'd2 : 2'd1;
      sc = 2'd2;
      sr = 2'd2;
    end else begin
      sl = (col == CW'(1)) ? 2'd1 : 2'd0;
      sc = 2'd1;
      sr = 2'd2;
    end
    for (int r = 0; r < 3; r++) begin
      a[r][0] = corner ? win[r*3+32'(sl)] : nwin[r*3+32'(sl)];
      a[r][1] = corner ? win[r*3+32'(sc)] : nwin[r*3+32'(sc)];
      a[r][2] = corner ? win[r*3+32'(sr)] : nwin[r*3+32'(sr)];
    end
    gx_next = (signed'(GW'(a[0][2])) + (signed'(GW'(a[1][2])) <<< 1) + signed'(GW'(a[2][2])))
            - (signed'(GW'(a[0][0])) + (signed'(GW'(a[1][0])) <<< 1) + signed'(GW'(a[2][0])));
    gy_next = (signed'(GW'(a[2][0])) + (signed'(GW'(a[2][1])) <<< 1) + signed'(GW'(a[2][2])))
            - (signed'(GW'(a[0][0])) + (signed'(GW'(a[0][1])) <<< 1) + signed'(GW'(a[0][2])));
    colp = {1'b0, col} + (CW+1)'(1);
  end

  // iteration datapath
  logic [RW+1:0] remsh, trial;
  logic signed [XW-1:0] dx, dy;
  logic [3:0] ci;

  always_comb begin
    remsh = {rem[RW-1:0], opnd[SQW-1 -: 2]};
    trial = {root, 2'b01};
    ci    = 4'(cnt);
    dx    = cy >>> ci;
    dy    = cx >>> ci;
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      upper_rd  <= upper_mem[ncol];
      middle_rd <= middle_mem[ncol];
    end
    if (state == S_WIN && !stray && !fin && !drain) begin
      upper_mem[col]  <= middle_rd;
      middle_mem[col] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_width   <= 11'd640;
      frame_height  <= 16'd480;
      channel_count <= 2'd3;
      col           <= '0;
      row           <= '0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   frame_width   <= cfg_data[10:0];
          REG_FRAME_HEIGHT:  frame_height  <= cfg_data[15:0];
          REG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            col   <= ncol;
            row   <= nrow;
            pix   <= pix_next;
            cmd   <= command;
            state <= S_WIN;
          end
        end
        S_WIN: begin
          gx   <= gx_next;
          gy   <= gy_next;
          last <= corner && fin;
          if (stray) begin
            state <= S_IDLE;
          end else if (fin) begin
            col   <= '0;
            row   <= '0;
            state <= corner ? S_SQ : S_IDLE;
          end else begin
            for (int k = 0; k < 9; k++) begin
              win[k] <= nwin[k];
            end
            if (32'(colp) >= 32'(w_eff)) begin
              col <= '0;
              row <= row + RWW'(1);
            end else begin
              col <= colp[CW-1:0];
            end
            state <= (corner || emit) ? S_SQ : S_IDLE;
          end
        end
        S_SQ: begin
          sqx <= SQW'(gx * gx);
          sqy <= SQW'(gy * gy);
          spec <= (gy == '0) || (gx == '0);
          if (gy == '0) begin
            spec_dir <= (gx >= 0) ? DIR_ZERO : DIR_PI;
          end else begin
            spec_dir <= (gy > 0) ? DIR_UP : DIR_DOWN;
          end
          if (gx < 0) begin
            cx <= XW'(-gx) <<< 16;
            cy <= XW'(-gy) <<< 16;
            cz <= (gy > 0) ? ANG_PI : -ANG_PI;
          end else begin
            cx <= XW'(gx) <<< 16;
            cy <= XW'(gy) <<< 16;
            cz <= '0;
          end
          state <= S_SUM;
        end
        S_SUM: begin
          opnd  <= sqx + sqy;
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (32'(cnt) < RW) begin
            opnd <= opnd << 2;
            if (remsh >= trial) begin
              rem  <= remsh - trial;
              root <= {root[RW-2:0], 1'b1};
            end else begin
              rem  <= remsh;
              root <= {root[RW-2:0], 1'b0};
            end
          end
          if (32'(cnt) < CORDIC_STEPS) begin
            if (cy >= 0) begin
              cx <= cx + dx;
              cy <= cy - dy;
              cz <= cz + signed'(ANGLE_W'(atan_unit(ci)));
            end else begin
              cx <= cx - dx;
              cy <= cy + dy;
              cz <= cz - signed'(ANGLE_W'(atan_unit(ci)));
            end
          end
          cnt <= cnt + NW'(1);
          if (32'(cnt) == NIT - 1) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    grad_magnitude = 13'(root);
    frame_last     = last;
    if (spec) begin
      grad_direction = spec_dir;
    end else if (cz > ANGLE_W'(32767)) begin
      grad_direction = DIR_PI;
    end else if (cz < -ANG_PI) begin
      grad_direction = -16'sd32768;
    end else begin
      grad_direction = 16'(cz);
    end
  end

endmodule

### rtl/sgmd_checker.sv
// ----------------------------------------------------------------------------
// sgmd_checker
// Port-level checks on the Sobel gradient block.
// ----------------------------------------------------------------------------
module sgmd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [12:0]        grad_magnitude,
  input logic signed [15:0] grad_direction,
  input logic               frame_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(grad_magnitude)
      && $stable(grad_direction) && $stable(frame_last))
    else $error("result changed while stalled");

  a_zero_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && grad_magnitude == 13'd0 |-> grad_direction == 16'sd0)
    else $error("zero gradient with nonzero direction");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result waits");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result in cycle after accept");

endmodule

bind sobel_gradient_magnitude_direction sgmd_checker u_sgmd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .grad_magnitude(grad_magnitude), .grad_direction(grad_direction),
  .frame_last(frame_last)
);

### bench/sgmd_checker.sv
// ----------------------------------------------------------------------------
// sgmd_monitor
// Watches the pixel, result and register ports of the Sobel gradient block,
// predicts each gradient result from its own copy of the line stores and the
// 3x3 window, and compares every result field by field in order.
// ----------------------------------------------------------------------------
module sgmd_monitor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [sgmd_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       command,
  input  logic [7:0]                 chan0_value,
  input  logic [7:0]                 chan1_value,
  input  logic [7:0]                 chan2_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [12:0]                grad_magnitude,
  input  logic signed [15:0]         grad_direction,
  input  logic                       frame_last,
  output int                         errors,
  output int                         pending,
  output int                         checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sgmd_pkg::*;

  typedef struct packed {
    logic [12:0]        mag;
    logic signed [15:0] dir;
    logic               last;
  } gradient_t;

  gradient_t   gradient_q[$];
  int unsigned width_reg, height_reg, chans_reg;
  int unsigned upper_row[1024], middle_row[1024], window[9];
  int unsigned col_pos, row_pos;

  assign pending = gradient_q.size();

  task automatic flag_error(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic longint root_floor(input longint v);
    longint r, t;
    r = 0;
    for (int b = 12; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] angle_of(input longint gx, input longint gy);
    longint x, y, z, dx, dy;
    if (gy == 0) return (gx >= 0) ? DIR_ZERO : DIR_PI;
    if (gx == 0) return (gy > 0) ? DIR_UP : DIR_DOWN;
    x = gx;
    y = gy;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (gy > 0) ? 32768 : -32768;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_unit(4'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_unit(4'(i)));
      end
    end
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    return 16'(z);
  endfunction

  task automatic add_gradient(input int l, input int c, input int r, input bit last);
    longint a[3][3];
    longint gx, gy;
    gradient_t g;
    for (int k = 0; k < 3; k++) begin
      a[k][0] = window[k*3+l];
      a[k][1] = window[k*3+c];
      a[k][2] = window[k*3+r];
    end
    gx = (a[0][2] + 2*a[1][2] + a[2][2]) - (a[0][0] + 2*a[1][0] + a[2][0]);
    gy = (a[2][0] + 2*a[2][1] + a[2][2]) - (a[0][0] + 2*a[0][1] + a[0][2]);
    g.mag  = 13'(root_floor(gx*gx + gy*gy));
    g.dir  = angle_of(gx, gy);
    g.last = last;
    gradient_q.push_back(g);
  endtask

  task automatic take_pixel(input logic cmd, input logic [7:0] s0, s1, s2);
    int unsigned w, h, col, row, top, mid, bot, cc;
    bit drain;
    w = (width_reg == 0) ? 1 : (width_reg > 1024 ? 1024 : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    if (col_pos >= w) begin col_pos = 0; row_pos++; end
    if (row_pos > h + 1) begin row_pos = h + 1; col_pos = 0; end
    if (row_pos == h + 1) col_pos = 0;
    col = col_pos;
    row = row_pos;
    drain = row >= h;
    if (!drain && cmd == CMD_FLUSH) return;
    if (col == 0 && row >= 2) add_gradient(w == 1 ? 2 : 1, 2, 2, row == h + 1);
    if (row == h + 1) begin
      col_pos = 0;
      row_pos = 0;
      return;
    end
    top = upper_row[col];
    mid = middle_row[col];
    if (row == 1) top = mid;
    if (drain) begin
      bot = mid;
    end else begin
      cc = (chans_reg == 0) ? 1 : chans_reg;
      bot = s0;
      if (cc >= 2) bot += s1;
      if (cc >= 3) bot += s2;
      upper_row[col] = mid;
      middle_row[col] = bot;
    end
    for (int i = 0; i < 3; i++) begin
      window[i*3]   = window[i*3+1];
      window[i*3+1] = window[i*3+2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = bot;
    if (col >= 1 && row >= 1) add_gradient(col == 1 ? 1 : 0, 1, 2, 1'b0);
    col++;
    if (col >= w) begin col = 0; row++; end
    col_pos = col;
    row_pos = row;
  endtask

  initial begin
    errors = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    gradient_t g;
    if (rst) begin
      gradient_q.delete();
      width_reg = 640;
      height_reg = 480;
      chans_reg = 3;
      foreach (upper_row[i]) begin upper_row[i] = 0; middle_row[i] = 0; end
      foreach (window[i]) window[i] = 0;
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   width_reg = cfg_data[10:0];
          REG_FRAME_HEIGHT:  height_reg = cfg_data[15:0];
          REG_CHANNEL_COUNT: chans_reg = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (gradient_q.size() == 0) begin
          flag_error("result with no item pending");
        end else begin
          g = gradient_q.pop_front();
          if (grad_magnitude !== g.mag)
            flag_error($sformatf("magnitude %0d, expected %0d", grad_magnitude, g.mag));
          if (grad_direction !== g.dir)
            flag_error($sformatf("direction %0d, expected %0d", grad_direction, g.dir));
          if (frame_last !== g.last)
            flag_error($sformatf("frame_last %0b, expected %0b", frame_last, g.last));
        end
      end
      if (in_valid && !in_stall) take_pixel(command, chan0_value, chan1_value, chan2_value);
    end
  end

endmodule

### bench/sobel_gradient_magnitude_direction_test.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_direction_test
// Feeds whole frames of pixels through the Sobel gradient block under several
// frame sizes and channel counts, with stray and drain flushes and random
// stalls on both sides; the monitor predicts and compares every result.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_direction_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sgmd_pkg::*;

  logic               clk, rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid, in_stall, command;
  logic [7:0]         chan0_value, chan1_value, chan2_value;
  logic               out_valid, out_stall, frame_last;
  logic [12:0]        grad_magnitude;
  logic signed [15:0] grad_direction;
  int                 errors, pending, checked;
  int                 items_sent, frames_done, hold_left, burst_left;
  bit                 calm, want_hold;

  sobel_gradient_magnitude_direction dut (.*);

  sgmd_monitor u_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("timeout with %0d results outstanding", pending);
    $display("** sobel_gradient_magnitude_direction: FAILED **");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) hold_left--;
      else if (want_hold) begin
        want_hold = 1'b0;
        hold_left = 200;
      end else if (burst_left > 0) burst_left--;
      else if (!calm && $urandom_range(0, 5) == 0) burst_left = $urandom_range(1, 19);
      out_stall <= (hold_left > 0 || burst_left > 0);
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] a, b, c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    chan0_value <= a;
    chan1_value <= b;
    chan2_value <= c;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input int unsigned w, h, ch);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, ch);
  endtask

  // mode: 0 random, 1 vertical edge, 2 all zero, 3 all full scale
  task automatic run_frame(input int w, h, mode);
    logic [7:0] p;
    for (int i = 0; i < w * h; i++) begin
      if (!calm && $urandom_range(0, 19) == 0)
        send_item(CMD_FLUSH, $urandom, $urandom, $urandom);
      case (mode)
        1: p = ((i % w) >= w / 2) ? 8'hff : 8'h00;
        2: p = 8'h00;
        3: p = 8'hff;
        default: p = $urandom;
      endcase
      if (mode == 0) send_item(CMD_PIXEL, $urandom, $urandom, $urandom);
      else send_item(CMD_PIXEL, p, p, p);
    end
    for (int i = 0; i <= w; i++)
      send_item($urandom_range(0, 1) ? CMD_FLUSH : CMD_PIXEL, $urandom, $urandom, $urandom);
    frames_done++;
  endtask

  initial begin
    int w, h;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_PIXEL;
    chan0_value = '0;
    chan1_value = '0;
    chan2_value = '0;
    calm = 1'b0;
    want_hold = 1'b0;
    items_sent = 0;
    frames_done = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_frame(1, 1, 1);
    run_frame(1, 1, 3);
    set_frame(0, 0, 0);
    run_frame(1, 1, 0);
    set_frame(4, 3, 3);
    run_frame(4, 3, 1);
    set_frame(3, 2, 2);
    run_frame(3, 2, 2);

    // tall frame cut short by shrinking the height mid-frame
    set_frame(2, 65535, 3);
    for (int i = 0; i < 6; i++) send_item(CMD_PIXEL, $urandom, $urandom, $urandom);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 2);
    send_item(CMD_FLUSH, '0, '0, '0);

    want_hold = 1'b1;
    while (items_sent < 1700) begin
      if (items_sent > 1450) calm = 1'b1;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_frame(w, h, $urandom_range(0, 3));
      run_frame(w, h, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    $display("%0d items in %0d frames, %0d gradient results checked, %0d mismatches",
             items_sent, frames_done, checked, errors);
    if (errors == 0) begin
      $display("** sobel_gradient_magnitude_direction: PASSED **");
    end else begin
      $display("** sobel_gradient_magnitude_direction: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/sgmd_pkg.sv
rtl/sobel_gradient_magnitude_direction.sv
rtl/sgmd_checker.sv
bench/sgmd_checker.sv
bench/sobel_gradient_magnitude_direction_test.sv
